FILE: rtl/mhtf_pkg.sv
// ----------------------------------------------------------------------------
// mhtf_pkg
// Shared constants and saturation helpers for the moving harmonic trap
// force core.
// ----------------------------------------------------------------------------
package mhtf_pkg;

	// configuration port
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 48;

	localparam logic [CFG_AW-1:0] REG_REST_LENGTH    = 3'd0;
	localparam logic [CFG_AW-1:0] REG_LENGTH_RATE    = 3'd1;
	localparam logic [CFG_AW-1:0] REG_STIFFNESS      = 3'd2;
	localparam logic [CFG_AW-1:0] REG_STIFFNESS_RATE = 3'd3;
	localparam logic [CFG_AW-1:0] REG_GROUP_STEPS    = 3'd4;

	// stream words
	localparam int ITEM_W = 224;
	localparam int USER_W = 2;

	// tuser bit positions on the result side
	localparam int USR_GROUP_DONE    = 0;
	localparam int USR_ZERO_DISTANCE = 1;

	// product cap of the shared multiplier
	localparam logic [63:0] MUL_CAP = 64'h4000_0000_0000_0000;

	// largest force scale fed to the unit vector product
	localparam logic [33:0] FSCALE_MAX = 34'h1_FFFF_FFFF;

	// multiplier output shifts
	localparam logic [5:0] SH_NONE  = 6'd0;
	localparam logic [5:0] SH_Q16   = 6'd16;
	localparam logic [5:0] SH_HALF  = 6'd17;
	localparam logic [5:0] SH_RAMP  = 6'd24;
	localparam logic [5:0] SH_UNIT  = 6'd30;

	// quotient bit counts for the shared divider
	localparam logic [5:0] DIV_BITS_UNIT  = 6'd31;
	localparam logic [5:0] DIV_BITS_STEP  = 6'd32;
	localparam logic [5:0] DIV_BITS_GROUP = 6'd21;

	// magnitude and sign to signed 32-bit, saturating
	function automatic logic [31:0] sat32(input logic [63:0] m, input logic neg);
		logic [63:0] n;
		n = ~m + 64'd1;
		if (neg) begin
			return (m > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : n[31:0];
		end
		return (m > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
	endfunction

	// magnitude and sign to signed 48-bit, saturating
	function automatic logic [47:0] sat48(input logic [63:0] m, input logic neg);
		logic [63:0] n;
		n = ~m + 64'd1;
		if (neg) begin
			return (m > 64'h0000_8000_0000_0000) ? 48'h8000_0000_0000 : n[47:0];
		end
		return (m > 64'h0000_7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : m[47:0];
	endfunction

	// base plus signed ramp term, saturated to signed 32-bit
	function automatic logic [31:0] ramp32(input logic [31:0] base, input logic neg,
			input logic [63:0] m);
		logic signed [65:0] b;
		logic signed [65:0] a;
		logic signed [65:0] s;
		b = 66'($signed(base));
		a = $signed({2'b00, m});
		if (neg) begin
			a = -a;
		end
		s = b + a;
		if (s > 66'sd2147483647) begin
			return 32'h7FFF_FFFF;
		end
		if (s < -66'sd2147483648) begin
			return 32'h8000_0000;
		end
		return s[31:0];
	endfunction

endpackage

FILE: rtl/mhtf_mul.sv
// ----------------------------------------------------------------------------
// mhtf_mul
// Shared 64 x 64 multiplier built from four 32 x 32 partial products over
// successive cycles, with a right shift and a cap on the shifted result.
// ----------------------------------------------------------------------------
module mhtf_mul import mhtf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic [5:0]  shamt,
	output logic        done,
	output logic [63:0] prod,
	output logic [63:0] res
);

	logic [63:0]  a_q, b_q;
	logic [5:0]   sh_q;
	logic [127:0] acc_q;
	logic [63:0]  pp_q;
	logic [2:0]   cnt_q;
	logic         busy_q, done_q;

	logic [31:0]  a_l, b_l;
	logic [63:0]  pp_d;
	logic [1:0]   pp_idx;
	logic [127:0] pp_ext;
	logic [127:0] shifted;

	// limb select and partial product alignment
	always_comb begin
		a_l    = cnt_q[1] ? a_q[63:32] : a_q[31:0];
		b_l    = cnt_q[0] ? b_q[63:32] : b_q[31:0];
		pp_d   = {32'd0, a_l} * {32'd0, b_l};
		pp_idx = 2'(cnt_q - 3'd1);
		case (pp_idx) inside
			2'd0:       pp_ext = {64'd0, pp_q};
			2'd1, 2'd2: pp_ext = {32'd0, pp_q, 32'd0};
			default:    pp_ext = {pp_q, 64'd0};
		endcase
	end

	// shift and cap of the finished product
	always_comb begin
		shifted = acc_q >> sh_q;
		res     = ((|shifted[127:64]) || (shifted[63:0] > MUL_CAP)) ? MUL_CAP : shifted[63:0];
		prod    = acc_q[63:0];
	end

	assign done = done_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			sh_q  <= shamt;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q < 3'd4) begin
				pp_q <= pp_d;
			end
			if (cnt_q != 3'd0) begin
				acc_q <= acc_q + pp_ext;
			end
		end
	end

endmodule

FILE: rtl/mhtf_sqrt.sv
// ----------------------------------------------------------------------------
// mhtf_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle, giving
// the exact floor of the root of a 68-bit value.
// ----------------------------------------------------------------------------
module mhtf_sqrt import mhtf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [67:0] rad,
	output logic        done,
	output logic [33:0] root
);

	logic [67:0] rad_q;
	logic [39:0] rem_q;
	logic [33:0] root_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;

	logic [39:0] trial_rem;
	logic [39:0] trial;
	logic        ge;

	// one root digit
	always_comb begin
		trial_rem = {rem_q[37:0], rad_q[67:66]};
		trial     = {4'd0, root_q, 2'b01};
		ge        = (trial_rem >= trial);
	end

	assign done = done_q;
	assign root = root_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd34;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[65:0], 2'b00};
			rem_q  <= ge ? (trial_rem - trial) : trial_rem;
			root_q <= {root_q[32:0], ge};
		end
	end

endmodule

FILE: rtl/mhtf_div.sv
// ----------------------------------------------------------------------------
// mhtf_div
// Shared restoring divider, one quotient bit per cycle. The part of the
// dividend above the quotient bits must already be below the divisor.
// ----------------------------------------------------------------------------
module mhtf_div import mhtf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [33:0] den,
	input  logic [5:0]  nbits,
	output logic        done,
	output logic [31:0] quo,
	output logic [33:0] rem
);

	logic [34:0] rem_q;
	logic [63:0] sh_q;
	logic [33:0] den_q;
	logic [31:0] quo_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;

	logic [34:0] trial_rem;
	logic        ge;

	// one quotient bit
	always_comb begin
		trial_rem = {rem_q[33:0], sh_q[63]};
		ge        = (trial_rem >= {1'b0, den_q});
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q[33:0];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 35'(num >> nbits);
			sh_q  <= num << (7'd64 - {1'b0, nbits});
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (trial_rem - {1'b0, den_q}) : trial_rem;
			sh_q  <= {sh_q[62:0], 1'b0};
			quo_q <= {quo_q[30:0], ge};
		end
	end

endmodule

FILE: rtl/moving_harmonic_trap_force_core.sv
// ----------------------------------------------------------------------------
// moving_harmonic_trap_force_core
// Harmonic trap force, potential and work between a particle and a moving
// reference, computed by a sequencer over a shared multiplier, square root
// and divider.
// ----------------------------------------------------------------------------
// Usage
//   s_t* carries one word per particle pair and step; m_t* returns one result
//   word for each accepted word, in order. cfg_we/cfg_addr/cfg_data write the
//   trap registers; the user must do so only while the core is idle, as the
//   core does not enforce it. Unknown indexes are ignored. Each shared-unit
//   operation takes its own steps plus issue and completion in the sequencer.
//   Per word the sequencer runs three squares, the root, two ramp products,
//   the scale product, three unit divisions each followed by a product, the
//   energy and work products, the two bookkeeping divisions for a new step and
//   the output state. Coinciding particles skip the unit divisions, force and
//   work products; a step not later than the last accumulated one skips the
//   bookkeeping divisions.
//   One word is in flight at a time; s_tready is high only while the
//   sequencer is idle, so a new word is taken only once the previous one has
//   left the output state.
//   The result sits in an output register: a stalled receiver holds m_tdata
//   and m_tuser, and the sequencer waits in its last state until the
//   register is free, after which the next word can be taken.
//   Reset clears all trap registers (group size 1), the step history and the
//   work accumulator; the core is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module moving_harmonic_trap_force_core import mhtf_pkg::*; #(
	parameter int WINDOW = 100000
) (
	input  logic              clk,
	input  logic              arst_n,
	// step_number, part_x, part_y, part_z, ref_x, ref_y, ref_z
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [ITEM_W-1:0] s_tdata,
	// force_x, force_y, force_z, energy, work_step, work_group_sum
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [ITEM_W-1:0] m_tdata,
	// group_done, zero_distance
	output logic [USER_W-1:0] m_tuser,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_data
);

	typedef enum logic [13:0] {
		ST_IDLE   = 14'b00_0000_0000_0001,
		ST_SQ     = 14'b00_0000_0000_0010,
		ST_SQRT   = 14'b00_0000_0000_0100,
		ST_RAMP_R = 14'b00_0000_0000_1000,
		ST_RAMP_K = 14'b00_0000_0001_0000,
		ST_SCALE  = 14'b00_0000_0010_0000,
		ST_DIV    = 14'b00_0000_0100_0000,
		ST_FMUL   = 14'b00_0000_1000_0000,
		ST_EE     = 14'b00_0001_0000_0000,
		ST_ENERGY = 14'b00_0010_0000_0000,
		ST_WORK   = 14'b00_0100_0000_0000,
		ST_WDIV   = 14'b00_1000_0000_0000,
		ST_GDIV   = 14'b01_0000_0000_0000,
		ST_OUT    = 14'b10_0000_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		UNIT_NONE = 2'd0,
		UNIT_MUL  = 2'd1,
		UNIT_SQRT = 2'd2,
		UNIT_DIV  = 2'd3
	} unit_t;

	localparam logic [33:0] WINDOW_DEN = 34'(WINDOW);

	state_t state_q;
	logic   issued_q;
	logic [1:0] cidx_q;

	// trap registers
	logic [31:0] rest_q, stiff_q;
	logic [47:0] lrate_q, srate_q;
	logic [17:0] gsteps_q;

	// item and intermediate values
	logic [31:0] step_q;
	logic [31:0] mag_q [3];
	logic [2:0]  negd_q;
	logic [65:0] ssum_q;
	logic [33:0] dist_q;
	logic [31:0] r_q;
	logic [35:0] emag_q;
	logic        eneg_q;
	logic [31:0] kmag_q;
	logic        kneg_q;
	logic [63:0] sfull_q;
	logic [30:0] u_q;
	logic [63:0] ee_q;
	logic [31:0] force_q [3];
	logic [31:0] energy_q;
	logic [47:0] work_q;
	logic [31:0] win_q;
	logic [19:0] idx_q;
	logic        gdone_q;

	// step history and group sum
	logic [31:0] last_q, lastwin_q;
	logic        seen_q;
	logic [47:0] acc_q;

	// output register
	logic              m_tvalid_q;
	logic [ITEM_W-1:0] out_data_q;
	logic [USER_W-1:0] out_user_q;

	// shared unit ports
	unit_t       unit;
	logic [63:0] mul_a, mul_b, mul_prod, mul_res;
	logic [5:0]  mul_sh;
	logic        mul_done, sqrt_done, div_done, op_done;
	logic [33:0] sqrt_root;
	logic [63:0] div_num;
	logic [33:0] div_den, div_rem;
	logic [5:0]  div_bits;
	logic [31:0] div_quo;

	// derived values
	logic [47:0] lrmag, srmag;
	logic        lrneg, srneg;
	logic [31:0] k_d;
	logic [35:0] ext_d;
	logic        negs;
	logic [33:0] scale;
	logic        zero;
	logic        acc_en;
	logic [17:0] g_eff;
	logic [20:0] idx_inc;
	logic        out_free;
	logic        newwin;
	logic [47:0] acc_base;
	logic [48:0] acc_sum;
	logic [47:0] acc_sat;
	logic [32:0] drx, dry, drz;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign out_free = !m_tvalid_q || m_tready;

	// input differences
	always_comb begin
		drx = 33'($signed(s_tdata[159:128])) - 33'($signed(s_tdata[63:32]));
		dry = 33'($signed(s_tdata[191:160])) - 33'($signed(s_tdata[95:64]));
		drz = 33'($signed(s_tdata[223:192])) - 33'($signed(s_tdata[127:96]));
	end

	// rates, stiffness, extension, force scale and bookkeeping terms
	always_comb begin
		lrneg   = lrate_q[47];
		srneg   = srate_q[47];
		lrmag   = lrneg ? (~lrate_q + 48'd1) : lrate_q;
		srmag   = srneg ? (~srate_q + 48'd1) : srate_q;
		k_d     = ramp32(stiff_q, srneg, mul_res);
		ext_d   = {2'b00, dist_q} - {{4{r_q[31]}}, r_q};
		negs    = eneg_q ^ kneg_q;
		scale   = (sfull_q > {30'd0, FSCALE_MAX}) ? FSCALE_MAX : sfull_q[33:0];
		zero    = (dist_q == 34'd0);
		acc_en  = !seen_q || (step_q > last_q);
		g_eff   = (gsteps_q == 18'd0) ? 18'd1 : gsteps_q;
		idx_inc = {1'b0, idx_q} + 21'd1;
	end

	// group sum update
	always_comb begin
		newwin   = !seen_q || (win_q != lastwin_q);
		acc_base = newwin ? 48'd0 : acc_q;
		acc_sum  = {acc_base[47], acc_base} + {work_q[47], work_q};
		if (acc_sum[48] != acc_sum[47]) begin
			acc_sat = acc_sum[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
		end else begin
			acc_sat = acc_sum[47:0];
		end
	end

	// operand routing to the shared units
	always_comb begin
		unit     = UNIT_NONE;
		mul_a    = '0;
		mul_b    = '0;
		mul_sh   = SH_NONE;
		div_num  = '0;
		div_den  = '0;
		div_bits = DIV_BITS_UNIT;
		unique case (state_q)
			ST_SQ: begin
				unit  = UNIT_MUL;
				mul_a = {32'd0, mag_q[cidx_q]};
				mul_b = {32'd0, mag_q[cidx_q]};
			end
			ST_SQRT: begin
				unit = UNIT_SQRT;
			end
			ST_RAMP_R: begin
				unit   = UNIT_MUL;
				mul_a  = {16'd0, lrmag};
				mul_b  = {32'd0, step_q};
				mul_sh = SH_RAMP;
			end
			ST_RAMP_K: begin
				unit   = UNIT_MUL;
				mul_a  = {16'd0, srmag};
				mul_b  = {32'd0, step_q};
				mul_sh = SH_RAMP;
			end
			ST_SCALE: begin
				unit   = UNIT_MUL;
				mul_a  = {28'd0, emag_q};
				mul_b  = {32'd0, kmag_q};
				mul_sh = SH_Q16;
			end
			ST_DIV: begin
				unit    = UNIT_DIV;
				div_num = {32'd0, mag_q[cidx_q]} << 30;
				div_den = dist_q;
			end
			ST_FMUL: begin
				unit   = UNIT_MUL;
				mul_a  = {30'd0, scale};
				mul_b  = {33'd0, u_q};
				mul_sh = SH_UNIT;
			end
			ST_EE: begin
				unit   = UNIT_MUL;
				mul_a  = {28'd0, emag_q};
				mul_b  = {28'd0, emag_q};
				mul_sh = SH_Q16;
			end
			ST_ENERGY: begin
				unit   = UNIT_MUL;
				mul_a  = ee_q;
				mul_b  = {32'd0, kmag_q};
				mul_sh = SH_HALF;
			end
			ST_WORK: begin
				unit   = UNIT_MUL;
				mul_a  = sfull_q;
				mul_b  = {16'd0, lrmag};
				mul_sh = SH_Q16;
			end
			ST_WDIV: begin
				unit     = UNIT_DIV;
				div_num  = {32'd0, step_q};
				div_den  = WINDOW_DEN;
				div_bits = DIV_BITS_STEP;
			end
			ST_GDIV: begin
				unit     = UNIT_DIV;
				div_num  = {43'd0, idx_inc};
				div_den  = {16'd0, g_eff};
				div_bits = DIV_BITS_GROUP;
			end
			default: begin
				unit = UNIT_NONE;
			end
		endcase
	end

	assign op_done = mul_done || sqrt_done || div_done;

	mhtf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  ((unit == UNIT_MUL) && !issued_q),
		.a      (mul_a),
		.b      (mul_b),
		.shamt  (mul_sh),
		.done   (mul_done),
		.prod   (mul_prod),
		.res    (mul_res)
	);

	mhtf_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  ((unit == UNIT_SQRT) && !issued_q),
		.rad    ({2'b00, ssum_q}),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	mhtf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  ((unit == UNIT_DIV) && !issued_q),
		.num    (div_num),
		.den    (div_den),
		.nbits  (div_bits),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q   <= '0;
			lrate_q  <= '0;
			stiff_q  <= '0;
			srate_q  <= '0;
			gsteps_q <= 18'd1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_REST_LENGTH:    rest_q   <= cfg_data[31:0];
				REG_LENGTH_RATE:    lrate_q  <= cfg_data;
				REG_STIFFNESS:      stiff_q  <= cfg_data[31:0];
				REG_STIFFNESS_RATE: srate_q  <= cfg_data;
				REG_GROUP_STEPS:    gsteps_q <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	// sequencer and step history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			issued_q   <= 1'b0;
			cidx_q     <= 2'd0;
			m_tvalid_q <= 1'b0;
			seen_q     <= 1'b0;
			last_q     <= '0;
			lastwin_q  <= '0;
			acc_q      <= '0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if ((unit != UNIT_NONE) && !issued_q) begin
				issued_q <= 1'b1;
			end else if (op_done) begin
				issued_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_SQ;
						cidx_q  <= 2'd0;
					end
				end
				ST_SQ: begin
					if (op_done) begin
						if (cidx_q == 2'd2) begin
							cidx_q  <= 2'd0;
							state_q <= ST_SQRT;
						end else begin
							cidx_q <= cidx_q + 2'd1;
						end
					end
				end
				ST_SQRT: begin
					if (op_done) state_q <= ST_RAMP_R;
				end
				ST_RAMP_R: begin
					if (op_done) state_q <= ST_RAMP_K;
				end
				ST_RAMP_K: begin
					if (op_done) state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (op_done) begin
						cidx_q  <= 2'd0;
						state_q <= zero ? ST_EE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (op_done) state_q <= ST_FMUL;
				end
				ST_FMUL: begin
					if (op_done) begin
						if (cidx_q == 2'd2) begin
							cidx_q  <= 2'd0;
							state_q <= ST_EE;
						end else begin
							cidx_q  <= cidx_q + 2'd1;
							state_q <= ST_DIV;
						end
					end
				end
				ST_EE: begin
					if (op_done) state_q <= ST_ENERGY;
				end
				ST_ENERGY: begin
					if (op_done) begin
						if (!zero) begin
							state_q <= ST_WORK;
						end else begin
							state_q <= acc_en ? ST_WDIV : ST_OUT;
						end
					end
				end
				ST_WORK: begin
					if (op_done) state_q <= acc_en ? ST_WDIV : ST_OUT;
				end
				ST_WDIV: begin
					if (op_done) state_q <= ST_GDIV;
				end
				ST_GDIV: begin
					if (op_done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (acc_en) begin
							seen_q    <= 1'b1;
							last_q    <= step_q;
							lastwin_q <= win_q;
							acc_q     <= gdone_q ? 48'd0 : acc_sat;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					step_q    <= s_tdata[31:0];
					mag_q[0]  <= drx[32] ? 32'(-drx) : drx[31:0];
					mag_q[1]  <= dry[32] ? 32'(-dry) : dry[31:0];
					mag_q[2]  <= drz[32] ? 32'(-drz) : drz[31:0];
					negd_q    <= {drz[32], dry[32], drx[32]};
					ssum_q    <= '0;
					work_q    <= '0;
					win_q     <= '0;
					gdone_q   <= 1'b0;
				end
			end
			ST_SQ: begin
				if (op_done) ssum_q <= ssum_q + {2'b00, mul_prod};
			end
			ST_SQRT: begin
				if (op_done) dist_q <= sqrt_root;
			end
			ST_RAMP_R: begin
				if (op_done) r_q <= ramp32(rest_q, lrneg, mul_res);
			end
			ST_RAMP_K: begin
				if (op_done) begin
					kneg_q <= k_d[31];
					kmag_q <= k_d[31] ? (~k_d + 32'd1) : k_d;
					eneg_q <= ext_d[35];
					emag_q <= ext_d[35] ? (~ext_d + 36'd1) : ext_d;
				end
			end
			ST_SCALE: begin
				if (op_done) begin
					sfull_q <= mul_res;
					if (zero) begin
						force_q[0] <= '0;
						force_q[1] <= '0;
						force_q[2] <= '0;
					end
				end
			end
			ST_DIV: begin
				if (op_done) u_q <= div_quo[30:0];
			end
			ST_FMUL: begin
				if (op_done) force_q[cidx_q] <= sat32(mul_res, negs ^ negd_q[cidx_q]);
			end
			ST_EE: begin
				if (op_done) ee_q <= mul_res;
			end
			ST_ENERGY: begin
				if (op_done) energy_q <= sat32(mul_res, kneg_q);
			end
			ST_WORK: begin
				if (op_done) work_q <= sat48(mul_res, negs ^ lrneg);
			end
			ST_WDIV: begin
				if (op_done) begin
					win_q <= div_quo;
					idx_q <= div_rem[19:0];
				end
			end
			ST_GDIV: begin
				if (op_done) gdone_q <= (div_rem == 34'd0);
			end
			ST_OUT: begin
				if (out_free) begin
					out_data_q[31:0]    <= force_q[0];
					out_data_q[63:32]   <= force_q[1];
					out_data_q[95:64]   <= force_q[2];
					out_data_q[127:96]  <= energy_q;
					out_data_q[175:128] <= work_q;
					out_data_q[223:176] <= (acc_en && gdone_q) ? acc_sat : 48'd0;
					out_user_q[USR_GROUP_DONE]    <= acc_en && gdone_q;
					out_user_q[USR_ZERO_DISTANCE] <= zero;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/mhtf_checker.sv
// ----------------------------------------------------------------------------
// mhtf_checker
// Port-level checks on the result stream of the trap force core, attached
// to the top level by a bind.
// ----------------------------------------------------------------------------
module mhtf_checker import mhtf_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [ITEM_W-1:0] m_tdata,
	input logic [USER_W-1:0] m_tuser
);

	// a stalled word stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word withdrawn while stalled");

	// a stalled word keeps its contents
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// group sum only shown when a group closes
	a_sum_gated: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[USR_GROUP_DONE] |-> m_tdata[223:176] == 48'd0)
		else $error("group sum non-zero without group close");

	// coinciding particles give no force and no work
	a_zero_force: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[USR_ZERO_DISTANCE]
			|-> m_tdata[95:0] == 96'd0 && m_tdata[175:128] == 48'd0)
		else $error("force or work non-zero at zero distance");

endmodule

bind moving_harmonic_trap_force_core mhtf_checker u_mhtf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

FILE: tb/tb_moving_harmonic_trap_force_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_moving_harmonic_trap_force_core
// Self-checking bench for the moving harmonic trap force core: a bit-exact
// predictor of force, energy and work bookkeeping is fed every accepted word
// and each result word is compared field by field, in order, under several
// trap settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_moving_harmonic_trap_force_core;
	import mhtf_pkg::*;

	localparam int WIN = 100000;
	localparam int IDLE_LIMIT = 20000;
	localparam logic signed [63:0] S32_LO = -64'sd2147483648;
	localparam logic signed [63:0] S32_HI = 64'sd2147483647;
	localparam logic signed [63:0] S48_LO = -64'sd140737488355328;
	localparam logic signed [63:0] S48_HI = 64'sd140737488355327;
	localparam logic [63:0] FSC_MAX = 64'h1_FFFF_FFFF;
	localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd6;

	typedef struct packed {
		logic        zero_dist;
		logic        grp_done;
		logic [47:0] grp_sum;
		logic [47:0] work;
		logic [31:0] energy;
		logic [31:0] fz;
		logic [31:0] fy;
		logic [31:0] fx;
	} trap_result_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [ITEM_W-1:0] s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [ITEM_W-1:0] m_tdata;
	logic [USER_W-1:0] m_tuser;
	logic              cfg_we;
	logic [CFG_AW-1:0] cfg_addr;
	logic [CFG_DW-1:0] cfg_data;

	moving_harmonic_trap_force_core #(.WINDOW(WIN)) dut (.*);

	// predictor copy of registers and state
	logic [31:0] m_rest, m_stiff;
	logic [47:0] m_lrate, m_srate;
	logic [17:0] m_gsteps;
	logic [31:0] m_last_step;
	logic        m_seen;
	logic signed [63:0] m_acc;

	trap_result_t pending_results[$];
	int err_count = 0;
	int idle_cycles = 0;
	int words_sent = 0;
	int groups_closed = 0;
	int zero_hits = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	logic [31:0] step_cursor = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] with_sign(input logic [63:0] m, input logic neg);
		return neg ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [63:0] clip(input logic signed [63:0] v,
			input logic signed [63:0] lo, input logic signed [63:0] hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// exact product, shifted and capped
	function automatic logic [63:0] mul_cap(input logic [63:0] a, input logic [63:0] b,
			input int sh);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> sh;
		return (p > {64'd0, MUL_CAP}) ? MUL_CAP : p[63:0];
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [127:0] v);
		logic [63:0] r;
		logic [63:0] c;
		r = 0;
		for (int b = 34; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= v) r = c;
		end
		return r;
	endfunction

	// base plus rate times step, saturated to 32 bits
	function automatic logic signed [63:0] ramp_val(input logic [31:0] base,
			input logic [47:0] rate, input logic [31:0] step);
		logic signed [63:0] rt;
		logic signed [63:0] add;
		rt = $signed({{16{rate[47]}}, rate});
		add = with_sign(mul_cap(mag64(rt), {32'd0, step}, 24), rt < 0);
		return clip($signed({{32{base[31]}}, base}) + add, S32_LO, S32_HI);
	endfunction

	// expected result for one word, advancing the work bookkeeping
	function automatic trap_result_t trap_predict(input logic [ITEM_W-1:0] w);
		trap_result_t res;
		logic [31:0] step;
		logic signed [63:0] dr[3];
		logic [127:0] sq;
		logic [63:0] dlen, sfull, sc, u;
		logic signed [63:0] r, k, ext, rate, work, en, f;
		logic neg_s, zero;
		logic [63:0] g, idx;
		step = w[31:0];
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			dr[i] = $signed({{32{w[32*(4+i)+31]}}, w[32*(4+i) +: 32]})
				- $signed({{32{w[32*(1+i)+31]}}, w[32*(1+i) +: 32]});
			sq = sq + {64'd0, mag64(dr[i])} * {64'd0, mag64(dr[i])};
		end
		dlen = int_sqrt(sq);
		zero = (dlen == 0);
		r = ramp_val(m_rest, m_lrate, step);
		k = ramp_val(m_stiff, m_srate, step);
		rate = $signed({{16{m_lrate[47]}}, m_lrate});
		ext = $signed(dlen) - r;
		sfull = mul_cap(mag64(ext), mag64(k), 16);
		neg_s = (ext < 0) != (k < 0);
		sc = (sfull > FSC_MAX) ? FSC_MAX : sfull;
		res = '0;
		for (int i = 0; i < 3; i++) begin
			f = 0;
			if (!zero) begin
				u = (mag64(dr[i]) << 30) / dlen;
				f = with_sign((sc * u) >> 30, neg_s != (dr[i] < 0));
			end
			f = clip(f, S32_LO, S32_HI);
			case (i)
				0: res.fx = f[31:0];
				1: res.fy = f[31:0];
				default: res.fz = f[31:0];
			endcase
		end
		en = with_sign(mul_cap(mul_cap(mag64(ext), mag64(ext), 16), mag64(k), 17), k < 0);
		en = clip(en, S32_LO, S32_HI);
		res.energy = en[31:0];
		work = 0;
		if (!zero)
			work = clip(with_sign(mul_cap(sfull, mag64(rate), 16), neg_s != (rate < 0)),
				S48_LO, S48_HI);
		res.work = work[47:0];
		res.zero_dist = zero;
		// accumulate only on a strictly later step
		if (!m_seen || step > m_last_step) begin
			g = (m_gsteps != 0) ? 64'(m_gsteps) : 64'd1;
			idx = 64'(step) % WIN;
			if (!m_seen || (64'(step) / WIN) != (64'(m_last_step) / WIN)) m_acc = 0;
			m_acc = clip(m_acc + work, S48_LO, S48_HI);
			m_last_step = step;
			m_seen = 1'b1;
			if ((idx + 1) % g == 0) begin
				res.grp_done = 1'b1;
				res.grp_sum = m_acc[47:0];
				m_acc = 0;
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h want %h (t=%0t)", what, got, want, $realtime);
		err_count++;
	endtask

	// result checker and idle counter
	always @(posedge clk) begin
		trap_result_t want;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", 64'(m_tdata), 64'd0);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[31:0] !== want.fx)
					report_mismatch("force_x", 64'(m_tdata[31:0]), 64'(want.fx));
				if (m_tdata[63:32] !== want.fy)
					report_mismatch("force_y", 64'(m_tdata[63:32]), 64'(want.fy));
				if (m_tdata[95:64] !== want.fz)
					report_mismatch("force_z", 64'(m_tdata[95:64]), 64'(want.fz));
				if (m_tdata[127:96] !== want.energy)
					report_mismatch("energy", 64'(m_tdata[127:96]), 64'(want.energy));
				if (m_tdata[175:128] !== want.work)
					report_mismatch("work_step", 64'(m_tdata[175:128]), 64'(want.work));
				if (m_tdata[223:176] !== want.grp_sum)
					report_mismatch("work_group_sum", 64'(m_tdata[223:176]),
						64'(want.grp_sum));
				if (m_tuser[USR_GROUP_DONE] !== want.grp_done)
					report_mismatch("group_done", 64'(m_tuser[USR_GROUP_DONE]),
						64'(want.grp_done));
				if (m_tuser[USR_ZERO_DISTANCE] !== want.zero_dist)
					report_mismatch("zero_distance", 64'(m_tuser[USR_ZERO_DISTANCE]),
						64'(want.zero_dist));
				if (want.grp_done) groups_closed++;
				if (want.zero_dist) zero_hits++;
			end
		end
	end

	// receiver: random stalls plus requested long hold-offs
	initial begin
		int hold_cnt;
		hold_cnt = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_cnt = hold_req;
				hold_req = 0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// watchdog
	initial begin
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val[CFG_DW-1:0];
		case (idx)
			REG_REST_LENGTH:    m_rest = val[31:0];
			REG_LENGTH_RATE:    m_lrate = val[47:0];
			REG_STIFFNESS:      m_stiff = val[31:0];
			REG_STIFFNESS_RATE: m_srate = val[47:0];
			REG_GROUP_STEPS:    m_gsteps = val[17:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_trap(input logic [31:0] rl, input logic [47:0] lr,
			input logic [31:0] st, input logic [47:0] sr, input logic [17:0] gs);
		write_reg(REG_REST_LENGTH, 64'(rl));
		write_reg(REG_LENGTH_RATE, 64'(lr));
		write_reg(REG_STIFFNESS, 64'(st));
		write_reg(REG_STIFFNESS_RATE, 64'(sr));
		write_reg(REG_GROUP_STEPS, 64'(gs));
	endtask

	// offer one word, with optional idle gap, and predict at acceptance
	task automatic send_word(input logic [ITEM_W-1:0] w);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(trap_predict(w));
		words_sent++;
	endtask

	// lower valid and wait until every result has arrived
	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [ITEM_W-1:0] pack_word(input logic [31:0] step,
			input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
			input logic [31:0] rx, input logic [31:0] ry, input logic [31:0] rz);
		return {rz, ry, rx, pz, py, px, step};
	endfunction

	// random word: mostly advancing steps, some repeats, window edges and noise
	function automatic logic [ITEM_W-1:0] rand_word;
		int pick;
		logic [31:0] p[3], q[3];
		pick = $urandom_range(99);
		if (pick < 78) step_cursor = step_cursor + $urandom_range(1, 3);
		else if (pick < 84) step_cursor = step_cursor - $urandom_range(0, 2);
		else if (pick < 90) step_cursor = ((step_cursor / WIN) + 1) * WIN - $urandom_range(0, 3);
		else step_cursor = $urandom;
		pick = $urandom_range(99);
		for (int i = 0; i < 3; i++) begin
			p[i] = $urandom;
			if (pick < 70) q[i] = p[i] + $signed(32'($urandom_range(0, 32'h0008_0000)))
				- 32'sh0004_0000;
			else if (pick < 75) q[i] = p[i];
			else if (pick < 85) q[i] = ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
			else q[i] = $urandom;
		end
		return pack_word(step_cursor, p[0], p[1], p[2], q[0], q[1], q[2]);
	endfunction

	function automatic logic [47:0] rand_rate;
		logic [47:0] v;
		v = 48'({$urandom, $urandom} >> $urandom_range(0, 24));
		return $urandom_range(1) ? -v : v;
	endfunction

	task automatic run_random(input int n, input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) send_word(rand_word());
		drain();
	endtask

	// extremes of fields, coinciding points, stale steps, window edges
	task automatic test_directed;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_word(pack_word(0, 0, 0, 0, 0, 0, 0));
		send_word(pack_word(1, 32'h0001_0000, 0, 0, 0, 0, 0));
		drain();
		set_trap(32'h0000_8000, 48'h00_0100_0000_00, 32'h0002_0000, 48'hFF_FF00_0000_00, 18'd3);
		write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF);
		send_word(pack_word(2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_word(pack_word(3, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
			32'h1234_5678, 32'h1234_5678, 32'h1234_5678));
		send_word(pack_word(4, 0, 0, 0, 32'h0003_0000, 32'hFFFC_0000, 32'h0000_0001));
		send_word(pack_word(4, 0, 0, 0, 32'h0003_0000, 32'hFFFC_0000, 32'h0000_0001));
		send_word(pack_word(2, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0));
		send_word(pack_word(5, 0, 0, 0, 0, 32'h0001_0000, 0));
		send_word(pack_word(WIN - 1, 0, 0, 0, 0, 0, 32'h0010_0000));
		send_word(pack_word(WIN + 1, 0, 0, 0, 32'h0000_4000, 0, 0));
		send_word(pack_word(32'hFFFF_FFFF, 0, 0, 0, 32'h0100_0000, 0, 0));
		drain();
		// saturating extremes and group size zero
		set_trap(32'h8000_0000, 48'h7F_FFFF_FFFF_FF, 32'h7FFF_FFFF, 48'h7F_FFFF_FFFF_FF, 18'd0);
		m_seen = m_seen;
		send_word(pack_word(0, 32'h8000_0000, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
		send_word(pack_word(32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF, 0, 0));
		send_word(pack_word(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
		drain();
		set_trap(32'h7FFF_FFFF, 48'h80_0000_0000_00, 32'h8000_0000, 48'h80_0000_0000_00,
			18'h3FFFF);
		send_word(pack_word(10, 0, 0, 0, 32'h0000_0100, 32'h8000_0000, 0));
		send_word(pack_word(20, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
		send_word(pack_word(32'hFFFF_FFF0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
		drain();
		// group size 131072, larger than the window
		set_trap(0, 48'h00_0001_0000_00, 32'h0001_0000, 0, 18'd131072);
		step_cursor = 32'd30;
		for (int i = 0; i < 4; i++) send_word(rand_word());
		drain();
	endtask

	task automatic test_random_settings(input int n, input int idle_pct, input int stall_pct);
		set_trap($urandom >> $urandom_range(0, 16), rand_rate(),
			$urandom >> $urandom_range(0, 16), rand_rate(), 18'($urandom_range(1, 6)));
		run_random(n, idle_pct, stall_pct);
	endtask

	// long hold-off on the result side while words keep coming
	task automatic test_backpressure;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1500;
		for (int i = 0; i < 30; i++) send_word(rand_word());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		m_rest = 0;
		m_lrate = 0;
		m_stiff = 0;
		m_srate = 0;
		m_gsteps = 18'd1;
		m_last_step = 0;
		m_seen = 1'b0;
		m_acc = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_settings(180, 0, 0);
		test_random_settings(180, 76, 0);
		test_random_settings(180, 0, 76);
		test_random_settings(150, 36, 36);
		test_backpressure();
		repeat (300) @(posedge clk);
		$display("covered %0d words over several trap settings and idling patterns", words_sent);
		$display("%0d work groups closed, %0d zero-distance words", groups_closed, zero_hits);
		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: moving_harmonic_trap_force_core.f
rtl/mhtf_pkg.sv
rtl/mhtf_mul.sv
rtl/mhtf_sqrt.sv
rtl/mhtf_div.sv
rtl/moving_harmonic_trap_force_core.sv
rtl/mhtf_checker.sv
tb/tb_moving_harmonic_trap_force_core.sv
